@@ src/xeu_pkg.sv @@
// shared types, constants and a helper function for the xml entity unescape core
// no dependencies
package xeu_pkg;

  localparam int WINDOW      = 10;
  localparam int MAX_RESULTS = 12;
  localparam int PTR_W       = $clog2(WINDOW + 1);
  localparam int BUF_DEPTH   = 2 ** PTR_W;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CP_W        = 21;
  localparam int ACC_W       = CP_W + 4;
  localparam int NUM_NAMES   = 5;

  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SAT   = 21'h110000;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] UTF_2B   = 21'h000080;
  localparam logic [CP_W-1:0] UTF_3B   = 21'h000800;
  localparam logic [CP_W-1:0] UTF_4B   = 21'h010000;
  localparam logic [7:0]      LEAD_2B  = 8'hC0;
  localparam logic [7:0]      LEAD_3B  = 8'hE0;
  localparam logic [7:0]      LEAD_4B  = 8'hF0;
  localparam logic [7:0]      CONT_B   = 8'h80;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam logic [7:0] NAME_CHR [NUM_NAMES][4] = '{
    '{8'h6C, 8'h74, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h00, 8'h00},
    '{8'h61, 8'h6D, 8'h70, 8'h00},
    '{8'h71, 8'h75, 8'h6F, 8'h74},
    '{8'h61, 8'h70, 8'h6F, 8'h73}
  };
  localparam logic [PTR_W-1:0] NAME_LEN [NUM_NAMES] = '{
    PTR_W'(2), PTR_W'(2), PTR_W'(3), PTR_W'(4), PTR_W'(4)
  };
  localparam logic [7:0] NAME_OUT [NUM_NAMES] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    P_WS,
    P_DIG0,
    P_ZERO,
    P_ZX,
    P_DIG,
    P_STOP
  } phase_t;

  typedef struct packed {
    logic             start;
    logic             step;
    logic [7:0]       ch;
    logic [PTR_W-1:0] pos;
    logic [PTR_W-1:0] len;
  } dec_cmd_t;

  typedef struct packed {
    logic            ok;
    logic [1:0]      nm1;
    logic [3:0][7:0] bytes;
  } dec_res_t;

  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (hex && c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (hex && c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

@@ src/xeu_decode.sv @@
// entity body decoder: scans held bytes one per cycle, matches names, parses numbers
// depends on xeu_pkg
module xeu_decode (
  input  logic              clk,
  input  xeu_pkg::dec_cmd_t cmd,
  output xeu_pkg::dec_res_t res
);
  import xeu_pkg::*;

  logic [NUM_NAMES-1:0] name_ok_r, name_ok_nxt;
  logic                 hash_r, hash_nxt;
  logic                 hex_r, hex_nxt;
  logic                 neg_r, neg_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CP_W-1:0]      val_r, val_nxt;

  logic                 base16;
  logic [4:0]           dv;
  logic                 ws, sgn;
  logic [ACC_W-1:0]     acc;
  logic [CP_W-1:0]      sat_v;
  logic                 parse_en;
  logic [CP_W-1:0]      cp;
  logic [NUM_NAMES-1:0] name_hit;

  always_comb begin
    name_ok_nxt = name_ok_r;
    hash_nxt    = hash_r;
    hex_nxt     = hex_r;
    neg_nxt     = neg_r;
    phase_nxt   = phase_r;
    val_nxt     = val_r;
    base16      = (cmd.pos >= PTR_W'(2)) ? hex_r : 1'b0;
    dv          = digit_val(cmd.ch, base16);
    ws          = (cmd.ch == 8'h20) || (cmd.ch >= 8'h09 && cmd.ch <= 8'h0D);
    sgn         = (cmd.ch == 8'h2B) || (cmd.ch == 8'h2D);
    acc         = base16 ? {val_r, 4'b0} : ({4'b0, val_r} << 3) + ({4'b0, val_r} << 1);
    acc         = acc + ACC_W'(dv[3:0]);
    sat_v       = (acc > ACC_W'(CP_MAX)) ? CP_SAT : acc[CP_W-1:0];
    parse_en    = 1'b0;
    for (int k = 0; k < NUM_NAMES; k++) begin
      if (cmd.pos < NAME_LEN[k] && cmd.ch != NAME_CHR[k][cmd.pos[1:0]]) name_ok_nxt[k] = 1'b0;
    end
    if (cmd.pos == '0) hash_nxt = (cmd.ch == CH_HASH);
    else if (cmd.pos == PTR_W'(1) && (cmd.ch == 8'h78 || cmd.ch == 8'h58)) hex_nxt = 1'b1;
    else parse_en = 1'b1;
    if (parse_en) begin
      unique case (phase_r)
        P_WS, P_DIG0: begin
          if (phase_r == P_WS && ws) begin
            phase_nxt = P_WS;
          end else if (phase_r == P_WS && sgn) begin
            neg_nxt   = (cmd.ch == 8'h2D);
            phase_nxt = P_DIG0;
          end else if (base16 && cmd.ch == 8'h30) begin
            phase_nxt = P_ZERO;
          end else if (dv[4]) begin
            val_nxt   = CP_W'(dv[3:0]);
            phase_nxt = P_DIG;
          end else begin
            phase_nxt = P_STOP;
          end
        end
        P_ZERO: begin
          if (cmd.ch == 8'h78 || cmd.ch == 8'h58) phase_nxt = P_ZX;
          else if (dv[4]) begin
            val_nxt   = CP_W'(dv[3:0]);
            phase_nxt = P_DIG;
          end else phase_nxt = P_STOP;
        end
        P_ZX: begin
          if (dv[4]) begin
            val_nxt   = CP_W'(dv[3:0]);
            phase_nxt = P_DIG;
          end else phase_nxt = P_STOP;
        end
        P_DIG: begin
          if (dv[4]) val_nxt = sat_v;
          else phase_nxt = P_STOP;
        end
        P_STOP: phase_nxt = P_STOP;
        default: phase_nxt = P_STOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      name_ok_r <= '1;
      hash_r    <= 1'b0;
      hex_r     <= 1'b0;
      neg_r     <= 1'b0;
      phase_r   <= P_WS;
      val_r     <= '0;
    end else if (cmd.step) begin
      name_ok_r <= name_ok_nxt;
      hash_r    <= hash_nxt;
      hex_r     <= hex_nxt;
      neg_r     <= neg_nxt;
      phase_r   <= phase_nxt;
      val_r     <= val_nxt;
    end
  end

  always_comb begin
    res = '0;
    cp  = neg_r ? '0 : val_r;
    for (int k = 0; k < NUM_NAMES; k++) name_hit[k] = name_ok_r[k] && (cmd.len == NAME_LEN[k]);
    if (|name_hit) begin
      res.ok = 1'b1;
      for (int k = 0; k < NUM_NAMES; k++) if (name_hit[k]) res.bytes[0] = NAME_OUT[k];
    end else if (hash_r && cmd.len != '0 && cp != '0 && cp <= CP_MAX
                 && !(cp >= SURR_LO && cp <= SURR_HI)) begin
      res.ok = 1'b1;
      if (cp < UTF_2B) begin
        res.bytes[0] = cp[7:0];
      end else if (cp < UTF_3B) begin
        res.nm1      = 2'd1;
        res.bytes[0] = LEAD_2B | {3'b0, cp[10:6]};
        res.bytes[1] = CONT_B | {2'b0, cp[5:0]};
      end else if (cp < UTF_4B) begin
        res.nm1      = 2'd2;
        res.bytes[0] = LEAD_3B | {4'b0, cp[15:12]};
        res.bytes[1] = CONT_B | {2'b0, cp[11:6]};
        res.bytes[2] = CONT_B | {2'b0, cp[5:0]};
      end else begin
        res.nm1      = 2'd3;
        res.bytes[0] = LEAD_4B | {5'b0, cp[20:18]};
        res.bytes[1] = CONT_B | {2'b0, cp[17:12]};
        res.bytes[2] = CONT_B | {2'b0, cp[11:6]};
        res.bytes[3] = CONT_B | {2'b0, cp[5:0]};
      end
    end
  end

endmodule

@@ src/xml_entity_unescape_core.sv @@
// top level of the xml entity unescape core: byte buffer, sequencer, output stage
// depends on xeu_pkg and xeu_decode
//
// Decodes xml character entities in a byte stream. One sequencer works on each input
// transfer, and the input is not ready until that byte is done. A byte that passes straight
// through, opens an entity or is held in the entity window is latched, then handled; then the
// sequencer sees the buffer drained and hands the last output byte to the output register. A
// ';' that closes an entity is followed by a scan of the held bytes, a decision and the
// emission of each output byte. A failed entity emits a literal '&' and replays its held bytes
// and the byte that broke it at one byte per cycle, while the output is not stalled, through
// the same sequencer; at text end an open entity is flushed the same way, until nothing is
// held. Output backpressure stalls the sequencer outside the body scan for as long as the
// output register holds a byte that is not taken.
// The last output byte of each input byte that yields output carries tlast; the final byte of
// the text carries tuser as well. At most 12 output bytes come from one input byte.
module xml_entity_unescape_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // stream_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // text_end
);
  import xeu_pkg::*;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] r_r, r_nxt, s_r, s_nxt, e_r, e_nxt, j_r, j_nxt;
  logic             last_r, last_nxt, in_ent_r, in_ent_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_b_r, pend_b_nxt;
  logic             out_v_r, out_v_nxt, out_l_r, out_l_nxt, out_u_r, out_u_nxt;
  logic [7:0]       out_b_r, out_b_nxt;
  logic [1:0]       k_r, k_nxt, nd_r, nd_nxt;
  logic [3:0][7:0]  utf_r, utf_nxt;
  logic             fail_r, fail_nxt;
  logic [7:0]       buf_r [BUF_DEPTH];

  logic             accept, out_free, do_emit;
  logic [7:0]       emit_b, rd_b;
  logic [PTR_W-1:0] rd_addr, hcnt;
  dec_cmd_t         cmd;
  dec_res_t         res;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !out_v_r || out_tready;
  assign hcnt     = r_r - s_r;
  assign rd_addr  = (state_r == ST_SCAN) ? s_r + j_r : r_r;
  assign rd_b     = buf_r[rd_addr];

  xeu_decode u_dec (.clk(clk), .cmd(cmd), .res(res));

  always_comb begin
    state_nxt  = state_r;
    r_nxt      = r_r;
    s_nxt      = s_r;
    e_nxt      = e_r;
    j_nxt      = j_r;
    last_nxt   = last_r;
    in_ent_nxt = in_ent_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_b_nxt  = out_b_r;
    out_l_nxt  = out_l_r;
    out_u_nxt  = out_u_r;
    k_nxt      = k_r;
    nd_nxt     = nd_r;
    utf_nxt    = utf_r;
    fail_nxt   = fail_r;
    do_emit    = 1'b0;
    emit_b     = CH_AMP;
    cmd        = '{start: 1'b0, step: 1'b0, ch: rd_b, pos: j_r, len: hcnt};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          e_nxt     = e_r + PTR_W'(1);
          last_nxt  = in_tlast;
          cnt_nxt   = '0;
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        if (out_free) begin
          if (r_r == e_r) begin
            if (last_r && in_ent_r) begin
              do_emit    = 1'b1;
              r_nxt      = s_r;
              in_ent_nxt = 1'b0;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end else if (!in_ent_r) begin
            if (rd_b == CH_AMP) begin
              in_ent_nxt = 1'b1;
              s_nxt      = r_r + PTR_W'(1);
            end else begin
              do_emit = 1'b1;
              emit_b  = rd_b;
            end
            r_nxt = r_r + PTR_W'(1);
          end else if (rd_b == CH_SEMI) begin
            cmd.start = 1'b1;
            j_nxt     = '0;
            state_nxt = ST_SCAN;
          end else if ({1'b0, hcnt} + (PTR_W+1)'(1) < (PTR_W+1)'(WINDOW)) begin
            r_nxt = r_r + PTR_W'(1);
          end else begin
            do_emit    = 1'b1;
            r_nxt      = s_r;
            in_ent_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (j_r == hcnt) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
          if (res.ok) begin
            utf_nxt  = res.bytes;
            nd_nxt   = res.nm1;
            fail_nxt = 1'b0;
          end else begin
            utf_nxt[0] = CH_AMP;
            nd_nxt     = '0;
            fail_nxt   = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
          j_nxt    = j_r + PTR_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          do_emit = 1'b1;
          emit_b  = utf_r[k_r];
          if (k_r == nd_r) begin
            r_nxt      = fail_r ? s_r : r_r + PTR_W'(1);
            in_ent_nxt = 1'b0;
            state_nxt  = ST_PROC;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_v_r) begin
            out_v_nxt  = 1'b1;
            out_b_nxt  = pend_b_r;
            out_l_nxt  = 1'b1;
            out_u_nxt  = last_r;
            pend_v_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (do_emit && cnt_r < CNT_W'(MAX_RESULTS)) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_b_nxt = pend_b_r;
        out_l_nxt = 1'b0;
        out_u_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_b_nxt = emit_b;
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      r_r      <= '0;
      s_r      <= '0;
      e_r      <= '0;
      j_r      <= '0;
      last_r   <= 1'b0;
      in_ent_r <= 1'b0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      k_r      <= '0;
      nd_r     <= '0;
      fail_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      r_r      <= r_nxt;
      s_r      <= s_nxt;
      e_r      <= e_nxt;
      j_r      <= j_nxt;
      last_r   <= last_nxt;
      in_ent_r <= in_ent_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      k_r      <= k_nxt;
      nd_r     <= nd_nxt;
      fail_r   <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_b_r <= pend_b_nxt;
    out_b_r  <= out_b_nxt;
    out_l_r  <= out_l_nxt;
    out_u_r  <= out_u_nxt;
    utf_r    <= utf_nxt;
    if (accept) buf_r[e_r] <= in_tdata;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_b_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_u_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_v_r)
    else $error("pending byte left over at idle");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("text end without run end");

  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && in_ent_r) |-> ({1'b0, e_r - s_r} < (PTR_W+1)'(WINDOW)))
    else $error("held window too long at idle");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond cap");

endmodule
